// ----- hw/rtl/bcci_pkg.sv -----
// Shared types and constants for the blink code count indicator.
`timescale 1ns / 1ps
`default_nettype none

package bcci_pkg;

  // Fixed field widths.
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned MASK_W     = 6;
  localparam int unsigned SHOWN_W    = 4;
  localparam int unsigned DONE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Default number of banks that can be enabled.
  localparam int unsigned MAX_BANKS_DEF = 6;

  // Marks that no count has been shown since reset; never equals a real count.
  localparam logic [SHOWN_W-1:0] NONE_SHOWN = '1;

  // Register reset values in microseconds.
  localparam logic [LEN_W-1:0] BLINK_TIME_RST = LEN_W'(100000);
  localparam logic [LEN_W-1:0] PAUSE_TIME_RST = LEN_W'(1000000);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLINK_TIME = CFG_IDX_W'(0),
    REG_PAUSE_TIME = CFG_IDX_W'(1)
  } cfg_reg_e;

  typedef struct packed {
    logic [LEN_W-1:0] blink_time;
    logic [LEN_W-1:0] pause_time;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  time_now;
  } item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bcci_if.sv -----
// Handshake channel interfaces for the blink code count indicator.
`timescale 1ns / 1ps
`default_nettype none

interface bcci_in_if;
  logic                         valid;
  logic                         ready;
  logic [bcci_pkg::COUNT_W-1:0] count;
  logic [bcci_pkg::TIME_W-1:0]  time_now;

  modport source (output valid, output count, output time_now, input ready);
  modport sink (input valid, input count, input time_now, output ready);
endinterface

interface bcci_out_if;
  logic                        valid;
  logic                        ready;
  logic                        led_level;
  logic [bcci_pkg::MASK_W-1:0] bank_enables;

  modport source (output valid, output led_level, output bank_enables, input ready);
  modport sink (input valid, input led_level, input bank_enables, output ready);
endinterface

interface bcci_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bcci_pkg::CFG_IDX_W-1:0]  index;
  logic [bcci_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bcci_cfg_regs.sv -----
// Configuration registers for blink and pause lengths.
`timescale 1ns / 1ps
`default_nettype none

module bcci_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  bcci_cfg_if.sink           cfg_i,
  output bcci_pkg::cfg_t     cfg_o
);

  bcci_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        bcci_pkg::REG_BLINK_TIME: cfg_d.blink_time = cfg_i.data[bcci_pkg::LEN_W-1:0];
        bcci_pkg::REG_PAUSE_TIME: cfg_d.pause_time = cfg_i.data[bcci_pkg::LEN_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_time <= bcci_pkg::BLINK_TIME_RST;
      cfg_q.pause_time <= bcci_pkg::PAUSE_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bcci_in_stage.sv -----
// Input register stage that captures one poll transaction.
`timescale 1ns / 1ps
`default_nettype none

module bcci_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  bcci_in_if.sink            in_i,
  input  wire logic          take_i,
  output logic               valid_o,
  output bcci_pkg::item_t    item_o
);

  logic            valid_q, valid_d;
  logic            accept;
  bcci_pkg::item_t item_q;

  // The stage frees up in the same cycle that the core takes its item.
  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.count    <= in_i.count;
      item_q.time_now <= in_i.time_now;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bcci_core.sv -----
// Blink state update, bank mask and result register.
`timescale 1ns / 1ps
`default_nettype none

module bcci_core #(
  parameter int unsigned MAX_BANKS = bcci_pkg::MAX_BANKS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bcci_pkg::cfg_t   cfg_i,
  input  wire logic             valid_i,
  input  wire bcci_pkg::item_t  item_i,
  output logic                  take_o,
  bcci_out_if.source            out_o
);

  localparam int unsigned SW = bcci_pkg::SHOWN_W;
  localparam int unsigned DW = bcci_pkg::DONE_W;
  localparam int unsigned TW = bcci_pkg::TIME_W;
  localparam int unsigned MW = bcci_pkg::MASK_W;

  // Blink state.
  logic [SW-1:0] shown_q, shown_d;
  logic [DW-1:0] done_q, done_d;
  logic          lamp_q, lamp_d;
  logic [TW-1:0] deadline_q, deadline_d;

  // Result register.
  logic          out_valid_q, out_valid_d;
  logic          out_led_q;
  logic [MW-1:0] out_mask_q;

  logic [SW-1:0] cnt;
  logic [MW-1:0] mask;
  logic [DW-1:0] done_inc;
  logic          due;
  logic          use_pause;
  logic [TW-1:0] next_deadline;

  assign take_o = valid_i && (!out_valid_q || out_o.ready);

  // Counts above the bank limit saturate.
  always_comb begin
    cnt = {1'b0, item_i.count};
    if ({1'b0, item_i.count} > SW'(MAX_BANKS)) begin
      cnt = SW'(MAX_BANKS);
    end
  end

  always_comb begin
    for (int i = 0; i < MW; i++) begin
      mask[i] = SW'(i) < cnt;
    end
  end

  assign due       = item_i.time_now >= deadline_q;
  assign done_inc  = done_q + DW'(1);
  // Only a falling edge that finishes the series starts the pause.
  assign use_pause = (cnt == shown_q) && lamp_q && ({1'b0, done_inc} >= cnt);
  assign next_deadline = item_i.time_now +
                         TW'(use_pause ? cfg_i.pause_time : cfg_i.blink_time);

  always_comb begin
    shown_d    = shown_q;
    done_d     = done_q;
    lamp_d     = lamp_q;
    deadline_d = deadline_q;
    if (take_o) begin
      if (cnt == '0) begin
        shown_d    = '0;
        done_d     = '0;
        lamp_d     = 1'b0;
        deadline_d = '0;
      end else if (cnt != shown_q) begin
        shown_d    = cnt;
        done_d     = '0;
        lamp_d     = 1'b1;
        deadline_d = next_deadline;
      end else if (due) begin
        lamp_d     = !lamp_q;
        deadline_d = next_deadline;
        if (lamp_q) begin
          done_d = use_pause ? '0 : done_inc;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q     <= bcci_pkg::NONE_SHOWN;
      done_q      <= '0;
      lamp_q      <= 1'b0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      shown_q     <= shown_d;
      done_q      <= done_d;
      lamp_q      <= lamp_d;
      deadline_q  <= deadline_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_led_q  <= lamp_d;
      out_mask_q <= mask;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.led_level    = out_led_q;
  assign out_o.bank_enables = out_mask_q;

  // The waiting result always shows the current lamp level.
  a_led_tracks_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_led_q == lamp_q)
    else $error("result LED level differs from lamp state");

  // A zero count keeps the lamp dark and the series empty.
  a_zero_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shown_q == '0 |-> !lamp_q && done_q == '0)
    else $error("lamp active while count is zero");

  // The blink counter stays below the count being shown.
  a_done_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shown_q != '0 && shown_q != bcci_pkg::NONE_SHOWN) |-> {1'b0, done_q} < shown_q)
    else $error("blink counter reached the shown count");

  // A new count always starts the series with the lamp on.
  a_change_lights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && cnt != '0 && cnt != shown_q) |=> lamp_q && done_q == '0)
    else $error("count change did not restart the series");

endmodule

`default_nettype wire

// ----- hw/rtl/blink_code_count_indicator_top.sv -----
// Top level of the blink code count indicator.
`timescale 1ns / 1ps
`default_nettype none

// Path: an accepted poll is captured in the input register and then moves into the result register.
// Throughput: one poll transaction per cycle; the input register and the result
// register pass items on in the same cycle, and a stalled output holds both.
// Reset (asynchronous, active low) empties both stages, sets the shown count to
// "none shown", clears the blink counter, lamp and deadline, and loads the
// default blink (100 ms) and pause (1 s) lengths.
module blink_code_count_indicator_top #(
  parameter int unsigned MAX_BANKS = bcci_pkg::MAX_BANKS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bcci_in_if.sink   in_i,
  bcci_out_if.source out_o,
  bcci_cfg_if.sink  cfg_i
);

  // Configuration values; the user must change them only while no poll is in flight; not enforced.
  bcci_pkg::cfg_t  cfg;

  // Input register to core handoff.
  logic            s1_valid;
  bcci_pkg::item_t s1_item;
  logic            s1_take;

  // Holds the blink and pause lengths written over the configuration channel.
  bcci_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Captures each accepted poll so that the core works from a registered item.
  bcci_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (s1_take),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  // Compares the time against the deadline, steps the blink series, builds the
  // bank mask and registers the result. The state advances only when the item
  // moves into the result register, so a stall never repeats an update.
  bcci_core #(
    .MAX_BANKS (MAX_BANKS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .item_i  (s1_item),
    .take_o  (s1_take),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_blink_code_count_indicator_top.sv -----
// Self-checking testbench for the blink code count indicator top level.
`timescale 1ns / 1ps

// The bench drives poll transactions into the block and predicts each indication
// (LED level and bank enable mask) with its own copy of the blink-code state. A
// monitor on the poll channel updates that copy on every accepted poll and
// queues the predicted indication. A second monitor on the result channel pops
// the oldest prediction and compares it field by field. Register writes go
// through the configuration channel only while nothing is in flight.
module tb_blink_code_count_indicator_top;

  localparam int unsigned COUNT_W    = bcci_pkg::COUNT_W;
  localparam int unsigned TIME_W     = bcci_pkg::TIME_W;
  localparam int unsigned LEN_W      = bcci_pkg::LEN_W;
  localparam int unsigned MASK_W     = bcci_pkg::MASK_W;
  localparam int unsigned SHOWN_W    = bcci_pkg::SHOWN_W;
  localparam int unsigned DONE_W     = bcci_pkg::DONE_W;
  localparam int unsigned CFG_IDX_W  = bcci_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = bcci_pkg::CFG_DATA_W;

  localparam int unsigned MAX_BANKS      = bcci_pkg::MAX_BANKS_DEF;
  localparam int unsigned LATENCY_CYCLES = 2;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned IDLE_PERCENT   = 33;
  localparam int unsigned STALL_CYCLES   = 150;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // One expected indication: what the LED and the bank enables must show.
  typedef struct packed {
    logic              led;
    logic [MASK_W-1:0] banks;
  } indication_t;

  logic clk_i;
  logic rst_ni;

  bcci_in_if  poll_if ();
  bcci_out_if ind_if ();
  bcci_cfg_if reg_if ();

  blink_code_count_indicator_top #(
    .MAX_BANKS(MAX_BANKS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (poll_if),
    .out_o (ind_if),
    .cfg_i (reg_if)
  );

  // 100 MHz clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state. It mirrors the block's registers and its blink-code
  // sequencer, and is updated only at accepted transactions.
  logic [LEN_W-1:0]   blink_len;
  logic [LEN_W-1:0]   pause_len;
  logic [SHOWN_W-1:0] shown_q;
  logic [DONE_W-1:0]  series_blinks;
  logic               lamp_q;
  logic [TIME_W-1:0]  next_change;

  indication_t pending_indications[$];

  // Shared controls and statistics.
  bit          idling_on;
  int unsigned hold_request;
  int unsigned polls_accepted;
  int unsigned indications_checked;
  int unsigned reg_writes;
  int unsigned mismatch_count;
  int unsigned orphan_count;

  // Advances the predicted sequencer by one poll and returns the indication
  // that the block must produce for it.
  function automatic indication_t predict_indication(input logic [COUNT_W-1:0] count,
                                                     input logic [TIME_W-1:0] now);
    logic [COUNT_W-1:0] eff_count;
    logic [MASK_W:0]    full_mask;
    indication_t        ind;

    // Counts above the number of banks saturate for both the mask and the blinks.
    eff_count = (count > COUNT_W'(MAX_BANKS)) ? COUNT_W'(MAX_BANKS) : count;
    full_mask = ((MASK_W+1)'(1) << eff_count) - (MASK_W+1)'(1);

    if (eff_count == '0) begin
      // A zero count clears the sequencer and keeps the lamp dark.
      shown_q       = '0;
      series_blinks = '0;
      lamp_q        = 1'b0;
      next_change   = '0;
    end else if ({1'b0, eff_count} != shown_q) begin
      // A new count restarts the series with the lamp on.
      shown_q       = {1'b0, eff_count};
      series_blinks = '0;
      lamp_q        = 1'b1;
      next_change   = now + TIME_W'(blink_len);
    end else if (now >= next_change) begin
      // The deadline is compared without any wrap handling.
      if (lamp_q) begin
        lamp_q        = 1'b0;
        series_blinks = series_blinks + DONE_W'(1);
        if (series_blinks >= eff_count) begin
          series_blinks = '0;
          next_change   = now + TIME_W'(pause_len);
        end else begin
          next_change = now + TIME_W'(blink_len);
        end
      end else begin
        lamp_q      = 1'b1;
        next_change = now + TIME_W'(blink_len);
      end
    end

    ind.led   = lamp_q;
    ind.banks = full_mask[MASK_W-1:0];
    return ind;
  endfunction

  // Poll channel monitor: every accepted poll yields exactly one indication.
  always @(posedge clk_i) begin
    if (rst_ni && poll_if.valid === 1'b1 && poll_if.ready === 1'b1) begin
      pending_indications.push_back(predict_indication(poll_if.count, poll_if.time_now));
      polls_accepted++;
    end
  end

  // Register channel monitor: keeps the predicted lengths in step with the block.
  // Writes to indexes that do not name a register leave everything as it was.
  always @(posedge clk_i) begin
    if (rst_ni && reg_if.valid === 1'b1 && reg_if.ready === 1'b1) begin
      reg_writes++;
      if (reg_if.index == bcci_pkg::REG_BLINK_TIME) begin
        blink_len = reg_if.data[LEN_W-1:0];
      end else if (reg_if.index == bcci_pkg::REG_PAUSE_TIME) begin
        pause_len = reg_if.data[LEN_W-1:0];
      end
    end
  end

  // Result channel checker: compares each indication with the oldest prediction.
  always @(posedge clk_i) begin
    indication_t want;
    if (rst_ni && ind_if.valid === 1'b1 && ind_if.ready === 1'b1) begin
      if (pending_indications.size() == 0) begin
        orphan_count++;
        if (orphan_count + mismatch_count <= MAX_REPORTS) begin
          $display("%0t: unexpected indication led=%b banks=%b", $realtime,
                   ind_if.led_level, ind_if.bank_enables);
        end
      end else begin
        want = pending_indications.pop_front();
        indications_checked++;
        if (ind_if.led_level !== want.led || ind_if.bank_enables !== want.banks) begin
          mismatch_count++;
          if (orphan_count + mismatch_count <= MAX_REPORTS) begin
            $display("%0t: indication mismatch: expected led=%b banks=%b, got led=%b banks=%b",
                     $realtime, want.led, want.banks, ind_if.led_level, ind_if.bank_enables);
          end
        end
      end
    end
  end

  // Result ready. A long hold-off requested by a test takes precedence; its
  // length is counted here, independently of the process that sends polls.
  always @(negedge clk_i) begin
    int unsigned hold_left;
    if (!rst_ni) begin
      ind_if.ready = 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        ind_if.ready = 1'b0;
        hold_left--;
      end else if (idling_on) begin
        ind_if.ready = ($urandom_range(0, 99) >= IDLE_PERCENT);
      end else begin
        ind_if.ready = 1'b1;
      end
    end
  end

  function automatic logic [TIME_W-1:0] random_time();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[TIME_W-1:0];
  endfunction

  // Offers one poll, with random idle cycles ahead of it, and returns at the
  // falling edge after the transaction. Valid stays high so that back-to-back
  // polls need no gap.
  task automatic send_poll(input logic [COUNT_W-1:0] count, input logic [TIME_W-1:0] now);
    while (idling_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      poll_if.valid = 1'b0;
      @(negedge clk_i);
    end
    poll_if.valid    = 1'b1;
    poll_if.count    = count;
    poll_if.time_now = now;
    do @(posedge clk_i); while (poll_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every predicted indication has come out,
  // then lets the pipeline settle.
  task automatic pause_sender();
    poll_if.valid = 1'b0;
    while (pending_indications.size() != 0) @(negedge clk_i);
    repeat (LATENCY_CYCLES + 2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    reg_if.valid = 1'b1;
    reg_if.index = index;
    reg_if.data  = data;
    do @(posedge clk_i); while (reg_if.ready !== 1'b1);
    @(negedge clk_i);
    reg_if.valid = 1'b0;
  endtask

  // Loads both lengths once the block is idle. The bits above the register
  // width are random, since the block must ignore them.
  task automatic set_lengths(input logic [LEN_W-1:0] blink, input logic [LEN_W-1:0] pause);
    pause_sender();
    write_reg(bcci_pkg::REG_BLINK_TIME, {8'($urandom()), blink});
    write_reg(bcci_pkg::REG_PAUSE_TIME, {8'($urandom()), pause});
  endtask

  // Well-formed blink sequences: time moves forward in steps of the order of
  // the phase lengths, the count mostly holds and now and then changes. A few
  // polls are noise: arbitrary count and time, or time jumping backward.
  task automatic run_series(input int unsigned polls);
    logic [TIME_W-1:0]  clock_us;
    logic [COUNT_W-1:0] count;
    int unsigned        roll;
    int unsigned        step_cap;

    clock_us = $urandom_range(0, 1) ? random_time() : TIME_W'($urandom_range(0, 1000));
    count    = COUNT_W'($urandom_range(1, 7));
    for (int unsigned n = 0; n < polls; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_poll(COUNT_W'($urandom()), random_time());
      end else begin
        if (roll < 8) begin
          clock_us = clock_us - TIME_W'($urandom_range(0, blink_len));
        end else if (roll < 16) begin
          count = COUNT_W'($urandom_range(0, 7));
        end
        step_cap = ($urandom_range(0, 99) < 75) ? blink_len : pause_len;
        clock_us = clock_us + TIME_W'($urandom_range(0, step_cap + step_cap / 2 + 1));
        send_poll(count, clock_us);
      end
    end
  endtask

  // Right after reset the default lengths apply and nothing has been shown,
  // so the first nonzero count starts a series.
  task automatic test_reset_state();
    send_poll(3'd3, '0);
    send_poll(3'd3, TIME_W'(99999));
    send_poll(3'd3, TIME_W'(100000));
  endtask

  // Every count value, including the one above the bank count that saturates,
  // at both ends of the time range.
  task automatic test_count_range();
    for (int unsigned c = 0; c <= 5; c++) begin
      send_poll(COUNT_W'(c), (c % 2 == 0) ? TIME_MAX : '0);
    end
    send_poll(3'd7, TIME_MAX);
    // Same effective count as before, so only the deadline decides; the
    // deadline has wrapped to a small value and time zero is below it.
    send_poll(3'd6, '0);
  endtask

  // A full series with short lengths: on, off, on, off, then the pause.
  task automatic test_blink_series();
    set_lengths(LEN_W'(1), LEN_W'(3));
    for (int unsigned t = 10; t <= 17; t++) begin
      send_poll(3'd2, TIME_W'(t));
    end
  endtask

  // Longest lengths near the top of the time range: the deadline wraps and the
  // unprotected compare lets the very next poll toggle the lamp.
  task automatic test_deadline_wrap();
    set_lengths(LEN_MAX, LEN_MAX);
    send_poll(3'd1, TIME_MAX - TIME_W'(15));
    send_poll(3'd1, TIME_MAX - TIME_W'(14));
  endtask

  // Zero lengths, written with only the ignored upper bits set: the lamp
  // toggles on every poll at the same time.
  task automatic test_zero_lengths();
    pause_sender();
    write_reg(bcci_pkg::REG_BLINK_TIME, {8'hFF, LEN_W'(0)});
    write_reg(bcci_pkg::REG_PAUSE_TIME, {8'hFF, LEN_W'(0)});
    send_poll(3'd4, TIME_W'(5));
    send_poll(3'd4, TIME_W'(5));
    send_poll(3'd4, TIME_W'(5));
  endtask

  // A write to an index that names no register must leave both lengths alone.
  task automatic test_unused_index();
    pause_sender();
    write_reg(CFG_IDX_W'($urandom_range(bcci_pkg::REG_PAUSE_TIME + 1,
                                        (1 << CFG_IDX_W) - 1)),
              $urandom());
    write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), $urandom());
    run_series(20);
  endtask

  // The result side holds off for a long stretch while polls keep coming, so
  // the block fills up and must stall its input.
  task automatic test_backpressure();
    set_lengths(LEN_W'(5), LEN_W'(20));
    hold_request = STALL_CYCLES;
    run_series(60);
  endtask

  // A long stretch at full rate on both sides, with the shortest nonzero lengths.
  task automatic test_unpaced_stream();
    set_lengths(LEN_W'(1), LEN_W'(1));
    idling_on = 1'b0;
    run_series(300);
    idling_on = 1'b1;
  endtask

  // Random sequences under several length settings, extremes among them.
  task automatic test_random_settings();
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_lengths(LEN_MAX, LEN_MAX);
        end
        1: begin
          set_lengths(LEN_W'($urandom_range(1, 30)), LEN_W'($urandom_range(1, 100)));
        end
        2: begin
          set_lengths(LEN_W'($urandom_range(1, LEN_MAX)), LEN_W'($urandom_range(1, LEN_MAX)));
        end
        default: begin
          set_lengths(LEN_W'($urandom_range(2, 12)), LEN_W'(1));
        end
      endcase
      run_series(260);
    end
  endtask

  // Run timeout.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    idling_on        = 1'b1;
    hold_request     = 0;
    poll_if.valid    = 1'b0;
    poll_if.count    = '0;
    poll_if.time_now = '0;
    ind_if.ready     = 1'b0;
    reg_if.valid     = 1'b0;
    reg_if.index     = '0;
    reg_if.data      = '0;

    // The predictor starts from the block's reset state.
    blink_len     = bcci_pkg::BLINK_TIME_RST;
    pause_len     = bcci_pkg::PAUSE_TIME_RST;
    shown_q       = bcci_pkg::NONE_SHOWN;
    series_blinks = '0;
    lamp_q        = 1'b0;
    next_change   = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_count_range();
    test_blink_series();
    test_deadline_wrap();
    test_zero_lengths();
    test_unused_index();
    test_backpressure();
    test_unpaced_stream();
    test_random_settings();

    pause_sender();

    $display("Checked %0d indications from %0d polls across %0d register writes.",
             indications_checked, polls_accepted, reg_writes);
    $display("Covered counts 0 to 7, zero and full-scale lengths, time wrap, and a %0d-cycle stall.",
             STALL_CYCLES);
    if (pending_indications.size() != 0) begin
      $display("%0d predicted indications never arrived.", pending_indications.size());
    end
    if (mismatch_count == 0 && orphan_count == 0 && pending_indications.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
